@@ design/sssd_pkg.sv @@
package sssd_pkg;

   // Text store depth and display size
   localparam int TEXT_DEPTH = 32;
   localparam int NUM_DIGITS = 4;

   // Derived widths
   localparam int POS_W = $clog2(TEXT_DEPTH);
   localparam int SUM_W = POS_W + 1;
   localparam int LEN_W = $clog2(TEXT_DEPTH + 1);
   localparam int DIG_W = $clog2(NUM_DIGITS);

   // Register and field widths
   localparam int PERIOD_W = 10;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd500;

   // Commands
   localparam logic [1:0] CMD_TICK    = 2'd0;
   localparam logic [1:0] CMD_WRITE   = 2'd1;
   localparam logic [1:0] CMD_LENGTH  = 2'd2;
   localparam logic [1:0] CMD_RESTART = 2'd3;

   // Character codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LAST  = 8'h7A;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [6:0] SEG_G      = 7'h01;
   localparam logic [6:0] SEG_BLANK  = 7'h00;

   // Segment patterns from '0' up to 'z', bit6 A down to bit0 G
   localparam int GLYPH_COUNT = 75;
   localparam logic [6:0] GLYPH_TABLE [0:GLYPH_COUNT-1] = '{
      7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h5E,
      7'h37, 7'h06, 7'h3C, 7'h57, 7'h0E, 7'h6A, 7'h15, 7'h1D, 7'h67, 7'h73, 7'h05, 7'h5B,
      7'h0F, 7'h3E, 7'h1C, 7'h5C, 7'h13, 7'h3B, 7'h6D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h08,
      7'h00, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h5E, 7'h37, 7'h06, 7'h3C, 7'h57,
      7'h0E, 7'h6A, 7'h15, 7'h1D, 7'h67, 7'h73, 7'h05, 7'h5B, 7'h0F, 7'h3E, 7'h1C, 7'h5C,
      7'h13, 7'h3B, 7'h6D
   };

   // Decode one ASCII character to segments
   function automatic logic [6:0] glyph_of(input logic [7:0] code);
      logic [7:0] offset;
      logic [6:0] segs;
      offset = code - CHAR_ZERO;
      if (code == CHAR_DASH) begin
         segs = SEG_G;
      end else if (code < CHAR_ZERO || code > CHAR_LAST) begin
         segs = SEG_BLANK;
      end else begin
         segs = GLYPH_TABLE[offset[6:0]];
      end
      return segs;
   endfunction

endpackage

@@ design/scrolling_seven_segment_driver_core.sv @@
// Scrolling seven-segment driver: shows a text of up to 32 characters through
// a four-digit multiplexed display and bounces the window between both ends.
// Each request item carries a command in req_tuser: a tick lights the next
// digit and returns one response item (segments, decimal point, digit number
// and window position); character writes, length writes and scroll restarts
// only update state and return nothing. A character followed by '.' lights
// its decimal point and the rest of that sweep reads one place further on.
// The block takes one item per clock cycle unless a response stalls: the whole
// state update and the character decode sit between the state registers and
// the response register, and the response register accepts a new item in the
// same cycle that its old one is taken. The text store sits in flip-flops
// with a valid bit per entry, so it reads blank after reset without a clearing
// pass. csr_wr_en writes the scroll period (ticks per window step) at once.
module scrolling_seven_segment_driver_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_index[4:0], char_code[12:5], new_length[18:13]
   input  logic [1:0]  req_tuser,   // command[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // segments[6:0], dot_on[7], digit_select[9:8],
                                    // window_start[14:10]
   // configuration
   input  logic        csr_wr_en,
   input  logic [9:0]  csr_wr_data
);

   localparam int POS_W = sssd_pkg::POS_W;
   localparam int SUM_W = sssd_pkg::SUM_W;
   localparam int LEN_W = sssd_pkg::LEN_W;
   localparam int DIG_W = sssd_pkg::DIG_W;
   localparam int PERIOD_W = sssd_pkg::PERIOD_W;
   localparam int TEXT_DEPTH = sssd_pkg::TEXT_DEPTH;

   // Request fields
   logic [1:0] command;
   logic [4:0] char_index;
   logic [7:0] char_code;
   logic [5:0] new_length;

   assign command    = req_tuser;
   assign char_index = req_tdata[4:0];
   assign char_code  = req_tdata[12:5];
   assign new_length = req_tdata[18:13];

   // State
   logic [PERIOD_W-1:0] period_ff;
   logic [7:0]          text_store_ff [TEXT_DEPTH];
   logic [TEXT_DEPTH-1:0] text_valid_ff;
   logic [TEXT_DEPTH-1:0] text_dot_ff;
   logic [LEN_W-1:0]    text_length_ff, text_length_in;
   logic [PERIOD_W-1:0] tick_count_ff, tick_count_in;
   logic [POS_W-1:0]    scroll_pos_ff, scroll_pos_in;
   logic                moving_right_ff, moving_right_in;
   logic [DIG_W-1:0]    digit_index_ff, digit_index_in;
   logic                dot_skip_ff, dot_skip_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic is_tick;
   logic write_en;
   logic [POS_W-1:0] write_addr;

   // Tick datapath
   logic [PERIOD_W-1:0] tick_inc;
   logic                step;
   logic [POS_W-1:0]    pos_step;
   logic                dir_step;
   logic [SUM_W-1:0]    base;
   logic [SUM_W-1:0]    seg_addr;
   logic [SUM_W-1:0]    look_addr;
   logic [7:0]          seg_char;
   logic [6:0]          segs;
   logic                dot;

   // Take a new item whenever the response slot is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign is_tick    = req_accept && (command == sssd_pkg::CMD_TICK);
   assign write_en   = req_accept && (command == sssd_pkg::CMD_WRITE)
                       && (32'(char_index) < TEXT_DEPTH);
   assign write_addr = POS_W'(char_index);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Scroll step and display read for one tick
   always_comb begin
      tick_inc = tick_count_ff + PERIOD_W'(1);
      step     = (tick_inc >= period_ff);
      pos_step = scroll_pos_ff;
      dir_step = moving_right_ff;
      if (step) begin
         if (!moving_right_ff) begin
            if (scroll_pos_ff < POS_W'(TEXT_DEPTH - 1)) begin
               pos_step = scroll_pos_ff + POS_W'(1);
            end
            if (32'(pos_step) + sssd_pkg::NUM_DIGITS + 32'(dot_skip_ff)
                >= 32'(text_length_ff)) begin
               dir_step = 1'b1;
            end
         end else begin
            if (scroll_pos_ff != '0) begin
               pos_step = scroll_pos_ff - POS_W'(1);
            end
            if (pos_step == '0) begin
               dir_step = 1'b0;
            end
         end
      end

      base      = SUM_W'(pos_step) + SUM_W'(digit_index_ff);
      seg_addr  = base + SUM_W'(dot_skip_ff);
      look_addr = base + SUM_W'(1);

      // Drop reads beyond the store and entries never written
      seg_char = 8'h00;
      if (seg_addr < SUM_W'(TEXT_DEPTH)) begin
         if (text_valid_ff[seg_addr[POS_W-1:0]]) begin
            seg_char = text_store_ff[seg_addr[POS_W-1:0]];
         end
      end
      segs = sssd_pkg::glyph_of(seg_char);

      // Look ahead for a decimal point inside the text
      dot = 1'b0;
      if (32'(look_addr) < 32'(text_length_ff)) begin
         dot = text_dot_ff[look_addr[POS_W-1:0]];
      end
   end

   // Next state
   always_comb begin
      text_length_in  = text_length_ff;
      tick_count_in   = tick_count_ff;
      scroll_pos_in   = scroll_pos_ff;
      moving_right_in = moving_right_ff;
      digit_index_in  = digit_index_ff;
      dot_skip_in     = dot_skip_ff;
      if (req_accept) begin
         case (command)
            sssd_pkg::CMD_TICK: begin
               tick_count_in   = step ? '0 : tick_inc;
               scroll_pos_in   = pos_step;
               moving_right_in = dir_step;
               if (digit_index_ff == DIG_W'(sssd_pkg::NUM_DIGITS - 1)) begin
                  digit_index_in = '0;
                  dot_skip_in    = 1'b0;
               end else begin
                  digit_index_in = digit_index_ff + DIG_W'(1);
                  dot_skip_in    = dot_skip_ff | dot;
               end
            end
            sssd_pkg::CMD_LENGTH: begin
               if (32'(new_length) > TEXT_DEPTH) begin
                  text_length_in = LEN_W'(TEXT_DEPTH);
               end else begin
                  text_length_in = LEN_W'(new_length);
               end
            end
            sssd_pkg::CMD_RESTART: begin
               scroll_pos_in   = '0;
               moving_right_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Response slot: load on a tick, clear when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (is_tick) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, 5'(pos_step), 2'(digit_index_ff), dot, segs};
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= sssd_pkg::PERIOD_RESET;
         text_valid_ff   <= '0;
         text_dot_ff     <= '0;
         text_length_ff  <= '0;
         tick_count_ff   <= '0;
         scroll_pos_ff   <= '0;
         moving_right_ff <= 1'b0;
         digit_index_ff  <= '0;
         dot_skip_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
         if (write_en) begin
            text_valid_ff[write_addr] <= 1'b1;
            text_dot_ff[write_addr]   <= (char_code == sssd_pkg::CHAR_DOT);
         end
         text_length_ff  <= text_length_in;
         tick_count_ff   <= tick_count_in;
         scroll_pos_ff   <= scroll_pos_in;
         moving_right_ff <= moving_right_in;
         digit_index_ff  <= digit_index_in;
         dot_skip_ff     <= dot_skip_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (write_en) begin
         text_store_ff[write_addr] <= char_code;
      end
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // A tick always leaves a response waiting
   assert property (@(posedge clock) disable iff (reset) is_tick |=> rsp_valid_ff)
      else $error("tick item produced no response");

   // Dot shift only lives inside a sweep, never at its first digit
   assert property (@(posedge clock) disable iff (reset)
      dot_skip_ff |-> (digit_index_ff != '0))
      else $error("dot shift survived the end of a sweep");

   // Moving right means the window is away from the left end
   assert property (@(posedge clock) disable iff (reset)
      moving_right_ff |-> (scroll_pos_ff != '0))
      else $error("moving right at position zero");

   // Window position and text length stay inside the store
   assert property (@(posedge clock) disable iff (reset)
      (32'(scroll_pos_ff) < TEXT_DEPTH) && (32'(text_length_ff) <= TEXT_DEPTH))
      else $error("window or length beyond text store");

   // A pending response is held while the sink stalls
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled response changed");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

   // Receiver hold-off length and watchdog limit, in cycles
   localparam int LONG_HOLD   = 400;
   localparam int STALL_LIMIT = 4000;

   // Segment patterns from '0' up to 'z', bit6 A down to bit0 G
   localparam logic [6:0] GLYPH_ROM [0:74] = '{
      7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h5E,
      7'h37, 7'h06, 7'h3C, 7'h57, 7'h0E, 7'h6A, 7'h15, 7'h1D, 7'h67, 7'h73, 7'h05, 7'h5B,
      7'h0F, 7'h3E, 7'h1C, 7'h5C, 7'h13, 7'h3B, 7'h6D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h08,
      7'h00, 7'h77, 7'h1F, 7'h4E, 7'h3D, 7'h4F, 7'h47, 7'h5E, 7'h37, 7'h06, 7'h3C, 7'h57,
      7'h0E, 7'h6A, 7'h15, 7'h1D, 7'h67, 7'h73, 7'h05, 7'h5B, 7'h0F, 7'h3E, 7'h1C, 7'h5C,
      7'h13, 7'h3B, 7'h6D
   };

   typedef struct {
      logic [1:0] cmd;
      logic [4:0] idx;
      logic [7:0] code;
      logic [5:0] len;
   } disp_req_type;

   typedef struct {
      logic [6:0] segs;
      logic       dot;
      logic [1:0] digit;
      logic [4:0] win;
   } lit_digit_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en   = 1'b0;
   logic [9:0]  csr_wr_data = '0;

   // Display model state
   logic [7:0]  text_mem [0:sssd_pkg::TEXT_DEPTH-1];
   logic [5:0]  text_len;
   logic [9:0]  tick_cnt;
   logic [4:0]  win_pos;
   logic        going_right;
   logic [1:0]  digit_idx;
   logic        dot_shift;
   logic [9:0]  period_cfg;

   // Item queues and run control
   disp_req_type   pending_q [$];
   lit_digit_type  shown_q [$];
   disp_req_type   on_bus;
   int          in_flight   = 0;
   int          err_count   = 0;
   int          tx_wait     = 0;
   int          rx_wait     = 0;
   int          rx_draw;
   int          hold_ask    = 0;
   int          hold_seen   = 0;
   int          quiet_cycles = 0;
   logic        tx_quiet    = 1'b0;
   logic        rx_quiet    = 1'b0;
   int          phase_period [0:5] = '{0, 2, 1023, 3, 1, 7};

   scrolling_seven_segment_driver_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Read one text position, blank beyond the store
   function automatic logic [7:0] read_char(input int pos);
      if (pos >= sssd_pkg::TEXT_DEPTH) begin
         return 8'h00;
      end
      return text_mem[pos];
   endfunction

   // Update the display model for one accepted item, queue the lit digit on a tick
   function automatic void apply_request(input disp_req_type r);
      int            base;
      logic [7:0]    c;
      lit_digit_type lit;
      case (r.cmd)
         sssd_pkg::CMD_WRITE: begin
            text_mem[r.idx] = r.code;
         end
         sssd_pkg::CMD_LENGTH: begin
            text_len = (r.len > sssd_pkg::TEXT_DEPTH) ? 6'(sssd_pkg::TEXT_DEPTH) : r.len;
         end
         sssd_pkg::CMD_RESTART: begin
            win_pos = '0;
            going_right = 1'b0;
         end
         default: begin
            // advance the tick counter and step the window on a full period
            tick_cnt = tick_cnt + 10'd1;
            if (tick_cnt >= period_cfg) begin
               tick_cnt = '0;
               if (!going_right) begin
                  if (win_pos < sssd_pkg::TEXT_DEPTH - 1) win_pos = win_pos + 5'd1;
                  if (int'(win_pos) + sssd_pkg::NUM_DIGITS + int'(dot_shift)
                      >= int'(text_len))
                     going_right = 1'b1;
               end else begin
                  if (win_pos > 0) win_pos = win_pos - 5'd1;
                  if (win_pos == 0) going_right = 1'b0;
               end
            end
            // decode the character under this digit
            base = int'(win_pos) + int'(digit_idx);
            c = read_char(base + int'(dot_shift));
            if (c == sssd_pkg::CHAR_DASH) begin
               lit.segs = sssd_pkg::SEG_G;
            end else if (c < sssd_pkg::CHAR_ZERO || c > sssd_pkg::CHAR_LAST) begin
               lit.segs = sssd_pkg::SEG_BLANK;
            end else begin
               lit.segs = GLYPH_ROM[c - sssd_pkg::CHAR_ZERO];
            end
            // light the point when a dot follows inside the text
            lit.dot = 1'b0;
            if (base + 1 < int'(text_len) && read_char(base + 1) == sssd_pkg::CHAR_DOT) begin
               lit.dot = 1'b1;
               dot_shift = 1'b1;
            end
            lit.digit = digit_idx;
            lit.win = win_pos;
            shown_q.push_back(lit);
            digit_idx = digit_idx + 2'd1;
            if (digit_idx == 0) dot_shift = 1'b0;
         end
      endcase
   endfunction

   // Driver: offer pending items, wait a drawn gap after each one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_wait <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(on_bus);
            in_flight = in_flight - 1;
         end
         if (!req_tvalid || req_tready) begin
            if (tx_wait > 0) begin
               tx_wait <= tx_wait - 1;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               on_bus = pending_q.pop_front();
               req_tuser <= on_bus.cmd;
               req_tdata <= {5'b0, on_bus.len, on_bus.code, on_bus.idx};
               req_tvalid <= 1'b1;
               tx_wait <= tx_quiet ? 0 : $urandom_range(0, 19);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each lit digit against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_wait <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (shown_q.size() == 0) begin
               $display("%0t: unexpected item, got %h", $time, rsp_tdata);
               err_count = err_count + 1;
            end else begin
               lit_digit_type want;
               want = shown_q.pop_front();
               if (rsp_tdata[6:0] !== want.segs) begin
                  $display("%0t: segments expected %h got %h", $time, want.segs,
                           rsp_tdata[6:0]);
                  err_count = err_count + 1;
               end
               if (rsp_tdata[7] !== want.dot) begin
                  $display("%0t: dot_on expected %b got %b", $time, want.dot, rsp_tdata[7]);
                  err_count = err_count + 1;
               end
               if (rsp_tdata[9:8] !== want.digit) begin
                  $display("%0t: digit_select expected %0d got %0d", $time, want.digit,
                           rsp_tdata[9:8]);
                  err_count = err_count + 1;
               end
               if (rsp_tdata[14:10] !== want.win) begin
                  $display("%0t: window_start expected %0d got %0d", $time, want.win,
                           rsp_tdata[14:10]);
                  err_count = err_count + 1;
               end
            end
         end
         // hold off on request, else wait a drawn stall after each item
         if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            rx_wait <= LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait <= rx_wait - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            rx_draw = rx_quiet ? 0 : $urandom_range(0, 19);
            if (rx_draw > 0) begin
               rx_wait <= rx_draw - 1;
               rsp_tready <= 1'b0;
            end
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: count cycles with no item moving
   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("scrolling_seven_segment_driver_core regression: fail");
      $finish;
   end

   task automatic queue_req(input logic [1:0] cmd, input logic [4:0] idx,
                            input logic [7:0] code, input logic [5:0] len);
      disp_req_type r;
      r.cmd = cmd;
      r.idx = idx;
      r.code = code;
      r.len = len;
      in_flight = in_flight + 1;
      pending_q.push_back(r);
   endtask

   // Pick a character, biased toward dots, dashes and decodable codes
   function automatic logic [7:0] pick_char();
      case ($urandom_range(0, 7))
         0, 1:    return sssd_pkg::CHAR_DOT;
         2:       return sssd_pkg::CHAR_DASH;
         3:       return sssd_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
         4:       return 8'h41 + 8'($urandom_range(0, 25));
         5:       return 8'h61 + 8'($urandom_range(0, 25));
         6:       return 8'($urandom_range(8'h3A, 8'h60));
         default: return 8'($urandom);
      endcase
   endfunction

   // Queue one random item of any command, random filler in unused fields
   task automatic queue_random();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 62)
         queue_req(sssd_pkg::CMD_TICK, 5'($urandom), 8'($urandom), 6'($urandom));
      else if (sel < 82)
         queue_req(sssd_pkg::CMD_WRITE, 5'($urandom), pick_char(), 6'($urandom));
      else if (sel < 94)
         queue_req(sssd_pkg::CMD_LENGTH, 5'($urandom), 8'($urandom),
                   ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 32)));
      else
         queue_req(sssd_pkg::CMD_RESTART, 5'($urandom), 8'($urandom), 6'($urandom));
   endtask

   // Load a fresh text, set its length and restart the scroll
   task automatic load_text();
      int n;
      n = $urandom_range(1, 32);
      for (int i = 0; i < n; i++)
         queue_req(sssd_pkg::CMD_WRITE, 5'(i), pick_char(), 6'($urandom));
      queue_req(sssd_pkg::CMD_LENGTH, 5'($urandom), 8'($urandom),
                ($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'(n));
      queue_req(sssd_pkg::CMD_RESTART, 5'($urandom), 8'($urandom), 6'($urandom));
   endtask

   // Wait until every item is accepted and every lit digit has come back
   task automatic wait_settled();
      while (in_flight > 0 || shown_q.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_period(input logic [9:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      period_cfg = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      csr_wr_data <= 10'($urandom);
      @(posedge clock);
   endtask

   initial begin
      // model state after reset
      for (int i = 0; i < sssd_pkg::TEXT_DEPTH; i++) text_mem[i] = 8'h00;
      text_len = '0;
      tick_cnt = '0;
      win_pos = '0;
      going_right = 1'b0;
      digit_idx = '0;
      dot_shift = 1'b0;
      period_cfg = sssd_pkg::PERIOD_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // blank text at the reset period
      repeat (4) queue_req(sssd_pkg::CMD_TICK, 5'd0, 8'd0, 6'd0);
      wait_settled();

      // decode extremes, dots, saturated and zero length, restart
      write_period(10'd1);
      queue_req(sssd_pkg::CMD_WRITE, 5'd0, sssd_pkg::CHAR_ZERO, 6'd0);
      queue_req(sssd_pkg::CMD_WRITE, 5'd1, sssd_pkg::CHAR_DOT, 6'd0);
      queue_req(sssd_pkg::CMD_WRITE, 5'd2, sssd_pkg::CHAR_LAST, 6'd0);
      queue_req(sssd_pkg::CMD_WRITE, 5'd3, sssd_pkg::CHAR_DASH, 6'd0);
      queue_req(sssd_pkg::CMD_WRITE, 5'd4, sssd_pkg::CHAR_ZERO - 8'd1, 6'd0);
      queue_req(sssd_pkg::CMD_WRITE, 5'd5, sssd_pkg::CHAR_LAST + 8'd1, 6'd0);
      queue_req(sssd_pkg::CMD_WRITE, 5'd6, 8'hFF, 6'd0);
      queue_req(sssd_pkg::CMD_WRITE, 5'd31, 8'h41, 6'd0);
      queue_req(sssd_pkg::CMD_WRITE, 5'd30, sssd_pkg::CHAR_DOT, 6'd0);
      queue_req(sssd_pkg::CMD_LENGTH, 5'd31, 8'hFF, 6'd63);
      repeat (6) queue_req(sssd_pkg::CMD_TICK, 5'd31, 8'hFF, 6'd63);
      queue_req(sssd_pkg::CMD_RESTART, 5'd0, 8'd0, 6'd0);
      queue_req(sssd_pkg::CMD_LENGTH, 5'd0, 8'd0, 6'd5);
      repeat (4) queue_req(sssd_pkg::CMD_TICK, 5'd0, 8'd0, 6'd0);
      queue_req(sssd_pkg::CMD_LENGTH, 5'd0, 8'd0, 6'd0);
      repeat (2) queue_req(sssd_pkg::CMD_TICK, 5'd0, 8'd0, 6'd0);
      wait_settled();

      // random phases over several scroll periods
      phase_period[5] = $urandom_range(4, 40);
      for (int p = 0; p < 6; p++) begin
         write_period(10'(phase_period[p]));
         tx_quiet <= (p == 1) || (p == 3);
         rx_quiet <= (p == 1);
         if (p == 3) hold_ask <= hold_ask + 1;
         load_text();
         repeat (52) queue_random();
         wait_settled();
      end

      repeat (8) @(posedge clock);
      if (err_count == 0 && shown_q.size() == 0) begin
         $display("scrolling_seven_segment_driver_core regression: pass");
      end else begin
         $display("scrolling_seven_segment_driver_core regression: fail");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/sssd_pkg.sv
design/scrolling_seven_segment_driver_core.sv
tb/tb.sv
